// ===== rtl/glq_pkg.sv =====
// glq_pkg: shared types and constants for the glyph quad layout block
// request/result structs, register indexes, sequencer states
// no dependencies
package glq_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int COORD_BITS_DEF  = 12;

    localparam int CODE_W   = 8;
    localparam int FIELD_W  = 12;
    localparam int ATLAS_W  = 12;
    localparam int SCALE_W  = 16;
    localparam int POS_W    = 24;
    localparam int UV_W     = 17;
    localparam int UV_FRAC  = 16;
    localparam int QUAD_W   = 14;
    localparam int VERTEX_W = 16;
    localparam int VERT_SHIFT = 2;   // four vertices per quad
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [POS_W-1:0]   POS_MAX          = 24'hFFFFFF;
    localparam logic [UV_W-1:0]    UV_ONE           = 17'h10000;
    localparam logic [ATLAS_W-1:0] ATLAS_RESET      = 12'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET      = 16'd256;
    localparam logic [POS_W-1:0]   LINE_MAX_RESET   = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1,
        CFG_GLYPH_SCALE  = 2'd2,
        CFG_MAX_LINE     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_PLACE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        UV_U_LEFT   = 2'd0,
        UV_U_RIGHT  = 2'd1,
        UV_V_BOTTOM = 2'd2,
        UV_V_TOP    = 2'd3
    } uv_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WSTART,
        ST_WWAIT,
        ST_UV_SETUP,
        ST_UV_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               mode;
        logic [CODE_W-1:0]  char_code;
        logic [FIELD_W-1:0] glyph_w;
        logic [FIELD_W-1:0] glyph_h;
        logic [FIELD_W-1:0] glyph_x;
        logic [FIELD_W-1:0] glyph_y;
        logic               first_of_string;
        logic               last_of_string;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]    x_left;
        logic [POS_W-1:0]    x_right;
        logic [UV_W-1:0]     u_left;
        logic [UV_W-1:0]     u_right;
        logic [UV_W-1:0]     v_bottom;
        logic [UV_W-1:0]     v_top;
        logic [VERTEX_W-1:0] first_vertex;
        logic                split_here;
        logic                end_of_string;
    } res_t;

endpackage

// ===== rtl/glq_ram.sv =====
// glq_ram: generic single-write, single-read ram with registered read data
// used for the glyph table; no dependencies
module glq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/glq_div.sv =====
// glq_div: shared restoring divider, one quotient bit per cycle
// starts from a given partial remainder; no package dependencies
module glq_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] steps,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] dvd_reg, dvd_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            dvd_next  = dividend;
            q_next    = '0;
            rem_next  = rem_init;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[NUM_W-2:0], 1'b0};
            q_next   = {q_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/glyph_quad_layout.sv =====
// glyph_quad_layout: text layout over a glyph atlas table
// uses glq_pkg, glq_ram (glyph table) and glq_div (shared serial divider)
//
// Usage
// - request channel (req_valid/req_stall/req_data): mode 0 writes one glyph
//   table entry at char_code and gives no result; mode 1 places a character
// - result channel (res_valid/res_stall/res_data): one result per mode 1 request
// - cfg_en/cfg_addr/cfg_data write atlas size, glyph scale and line limit;
//   write them only while the block is idle
// - a table write does not stall the request channel; req_stall stays low after it
// - a placement passes through table read, multiply, width division, four uv
//   divisions and finish before its result is loaded; the shared serial divider
//   computes one quotient bit a cycle, 16 + COORD_BITS bits for the scaled width and
//   16 for each of the four uv fractions; a uv edge that clamps to 0 or 1.0 skips
//   its division, as does zero glyph height for the width
// - req_stall is high from a placement until its result is loaded into the
//   output register; a held result does not block the next request, but the
//   following result waits until the held one is taken
// - reset clears pen, quad count, split state and registers to their defaults;
//   the glyph table is undefined until written
module glyph_quad_layout #(
    parameter int GLYPH_COUNT = glq_pkg::GLYPH_COUNT_DEF,
    parameter int COORD_BITS  = glq_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  glq_pkg::req_t                   req_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output glq_pkg::res_t                   res_data,
    input  logic                            cfg_en,
    input  logic [glq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [glq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW     = COORD_BITS;
    localparam int AW     = $clog2(GLYPH_COUNT);
    localparam int EW     = 4 * CW;
    localparam int PW     = glq_pkg::SCALE_W + CW;
    localparam int DW     = (CW > glq_pkg::ATLAS_W) ? CW : glq_pkg::ATLAS_W;
    localparam int SW     = DW + 2;
    localparam int CNT_W  = $clog2(PW + 1);
    localparam int POS_W  = glq_pkg::POS_W;
    localparam int UV_W   = glq_pkg::UV_W;
    localparam logic [glq_pkg::CODE_W:0] CODE_LIMIT = (glq_pkg::CODE_W + 1)'(GLYPH_COUNT);
    localparam logic [PW-1:0] POS_MAX_P = PW'(glq_pkg::POS_MAX);

    // configuration registers
    logic [glq_pkg::ATLAS_W-1:0] aw_reg, ah_reg;
    logic [glq_pkg::SCALE_W-1:0] scale_reg;
    logic [POS_W-1:0]            line_max_reg;

    // sequencer and item state
    glq_pkg::state_t   state_reg, state_next;
    glq_pkg::uv_sel_t  uv_idx_reg, uv_idx_next;
    logic              code_ok_reg, code_ok_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     ew_reg, ew_next, eh_reg, eh_next;
    logic [CW-1:0]     ex_reg, ex_next, ey_reg, ey_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [POS_W-1:0]  width_reg, width_next;
    logic [UV_W-1:0]   uv_reg [4];
    logic [UV_W-1:0]   uv_next [4];

    // string state
    logic [POS_W-1:0]            pen_reg, pen_next;
    logic [glq_pkg::QUAD_W-1:0]  quad_reg, quad_next;
    logic                        seen_reg, seen_next;

    // output register
    logic           res_valid_reg, res_valid_next;
    glq_pkg::res_t  res_reg, res_next;

    // table and divider
    logic              req_take;
    logic              code_ok;
    logic              ram_we, ram_re;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [CNT_W-1:0]  div_steps;
    logic [PW-1:0]     div_dvd, div_q;
    logic [DW-1:0]     div_rem, div_den;

    // uv edge selection
    logic signed [SW-1:0] uv_num, uv_den_s;
    logic [DW-1:0]        uv_den;

    // finishing arithmetic
    logic [POS_W-1:0]           pen_eff, right;
    logic [POS_W:0]             pen_sum;
    logic [glq_pkg::QUAD_W-1:0] quad_eff;
    logic                       seen_eff, split;
    logic                       out_free;

    assign req_take = req_valid && !req_stall;
    assign req_stall = state_reg != glq_pkg::ST_IDLE;
    assign code_ok  = {1'b0, req_data.char_code} < CODE_LIMIT;
    assign ram_we   = req_take && req_data.mode == glq_pkg::MODE_WRITE && code_ok;
    assign ram_re   = req_take && req_data.mode == glq_pkg::MODE_PLACE && code_ok;
    assign ram_wdata = {CW'(req_data.glyph_w), CW'(req_data.glyph_h),
                        CW'(req_data.glyph_x), CW'(req_data.glyph_y)};

    glq_ram #(
        .WIDTH (EW),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_data.char_code[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (req_data.char_code[AW-1:0]),
        .rdata (ram_rdata)
    );

    glq_div #(
        .NUM_W (PW),
        .DEN_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dvd),
        .rem_init (div_rem),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // numerator and divisor of the current uv edge
    always_comb
    begin
        uv_num = '0;
        uv_den = DW'(aw_reg);
        unique case (uv_idx_reg)
            glq_pkg::UV_U_LEFT:
            begin
                uv_num = $signed(SW'(ex_reg));
            end
            glq_pkg::UV_U_RIGHT:
            begin
                uv_num = $signed(SW'(ex_reg)) + $signed(SW'(ew_reg));
            end
            glq_pkg::UV_V_BOTTOM:
            begin
                uv_num = $signed(SW'(ah_reg)) - $signed(SW'(ey_reg)) - $signed(SW'(eh_reg));
                uv_den = DW'(ah_reg);
            end
            glq_pkg::UV_V_TOP:
            begin
                uv_num = $signed(SW'(ah_reg)) - $signed(SW'(ey_reg));
                uv_den = DW'(ah_reg);
            end
            default:
            begin
                uv_num = '0;
            end
        endcase
    end

    assign uv_den_s = $signed(SW'(uv_den));

    // pen advance and split decision
    assign pen_eff  = first_reg ? '0 : pen_reg;
    assign quad_eff = first_reg ? '0 : quad_reg;
    assign seen_eff = first_reg ? 1'b0 : seen_reg;
    assign pen_sum  = {1'b0, pen_eff} + {1'b0, width_reg};
    assign right    = pen_sum[POS_W] ? glq_pkg::POS_MAX : pen_sum[POS_W-1:0];
    assign split    = !seen_eff && line_max_reg != '0 && right >= line_max_reg;
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        uv_idx_next    = uv_idx_reg;
        code_ok_next   = code_ok_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        ew_next        = ew_reg;
        eh_next        = eh_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        prod_next      = prod_reg;
        width_next     = width_reg;
        uv_next        = uv_reg;
        pen_next       = pen_reg;
        quad_next      = quad_reg;
        seen_next      = seen_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        div_start      = 1'b0;
        div_steps      = CNT_W'(PW);
        div_dvd        = prod_reg;
        div_rem        = '0;
        div_den        = DW'(eh_reg);

        unique case (state_reg)
            glq_pkg::ST_IDLE:
            begin
                if (req_take && req_data.mode == glq_pkg::MODE_PLACE)
                begin
                    code_ok_next = code_ok;
                    first_next   = req_data.first_of_string;
                    last_next    = req_data.last_of_string;
                    state_next   = glq_pkg::ST_READ;
                end
            end
            glq_pkg::ST_READ:
            begin
                // entries beyond the table read as zero
                ew_next    = code_ok_reg ? ram_rdata[4*CW-1:3*CW] : '0;
                eh_next    = code_ok_reg ? ram_rdata[3*CW-1:2*CW] : '0;
                ex_next    = code_ok_reg ? ram_rdata[2*CW-1:CW]   : '0;
                ey_next    = code_ok_reg ? ram_rdata[CW-1:0]      : '0;
                state_next = glq_pkg::ST_MUL;
            end
            glq_pkg::ST_MUL:
            begin
                prod_next  = scale_reg * ew_reg;
                state_next = glq_pkg::ST_WSTART;
            end
            glq_pkg::ST_WSTART:
            begin
                uv_idx_next = glq_pkg::UV_U_LEFT;
                if (eh_reg == '0)
                begin
                    width_next = '0;
                    state_next = glq_pkg::ST_UV_SETUP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = glq_pkg::ST_WWAIT;
                end
            end
            glq_pkg::ST_WWAIT:
            begin
                if (div_done)
                begin
                    width_next = (div_q > POS_MAX_P) ? glq_pkg::POS_MAX : div_q[POS_W-1:0];
                    state_next = glq_pkg::ST_UV_SETUP;
                end
            end
            glq_pkg::ST_UV_SETUP:
            begin
                div_steps = CNT_W'(glq_pkg::UV_FRAC);
                div_dvd   = '0;
                div_rem   = uv_num[DW-1:0];
                div_den   = uv_den;
                if (uv_num <= $signed(SW'(0)))
                begin
                    uv_next[uv_idx_reg] = '0;
                end
                else if (uv_num >= uv_den_s)
                begin
                    // also covers a zero atlas size
                    uv_next[uv_idx_reg] = glq_pkg::UV_ONE;
                end
                else
                begin
                    div_start = 1'b1;
                end

                if (div_start)
                begin
                    state_next = glq_pkg::ST_UV_WAIT;
                end
                else if (uv_idx_reg == glq_pkg::UV_V_TOP)
                begin
                    state_next = glq_pkg::ST_FINISH;
                end
                else
                begin
                    uv_idx_next = glq_pkg::uv_sel_t'(uv_idx_reg + 2'd1);
                end
            end
            glq_pkg::ST_UV_WAIT:
            begin
                if (div_done)
                begin
                    uv_next[uv_idx_reg] = {1'b0, div_q[glq_pkg::UV_FRAC-1:0]};
                    if (uv_idx_reg == glq_pkg::UV_V_TOP)
                    begin
                        state_next = glq_pkg::ST_FINISH;
                    end
                    else
                    begin
                        uv_idx_next = glq_pkg::uv_sel_t'(uv_idx_reg + 2'd1);
                        state_next  = glq_pkg::ST_UV_SETUP;
                    end
                end
            end
            glq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    res_next.x_left        = pen_eff;
                    res_next.x_right       = right;
                    res_next.u_left        = uv_reg[glq_pkg::UV_U_LEFT];
                    res_next.u_right       = uv_reg[glq_pkg::UV_U_RIGHT];
                    res_next.v_bottom      = uv_reg[glq_pkg::UV_V_BOTTOM];
                    res_next.v_top         = uv_reg[glq_pkg::UV_V_TOP];
                    res_next.first_vertex  = glq_pkg::VERTEX_W'(quad_eff) << glq_pkg::VERT_SHIFT;
                    res_next.split_here    = split;
                    res_next.end_of_string = last_reg;
                    res_valid_next         = 1'b1;
                    pen_next               = right;
                    quad_next              = quad_eff + glq_pkg::QUAD_W'(1);
                    seen_next              = seen_eff || split;
                    state_next             = glq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = glq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glq_pkg::ST_IDLE;
            uv_idx_reg    <= glq_pkg::UV_U_LEFT;
            pen_reg       <= '0;
            quad_reg      <= '0;
            seen_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            uv_idx_reg    <= uv_idx_next;
            pen_reg       <= pen_next;
            quad_reg      <= quad_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_ok_reg <= code_ok_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        ew_reg      <= ew_next;
        eh_reg      <= eh_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        prod_reg    <= prod_next;
        width_reg   <= width_next;
        uv_reg      <= uv_next;
        res_reg     <= res_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg       <= glq_pkg::ATLAS_RESET;
            ah_reg       <= glq_pkg::ATLAS_RESET;
            scale_reg    <= glq_pkg::SCALE_RESET;
            line_max_reg <= glq_pkg::LINE_MAX_RESET;
        end
        else if (cfg_en)
        begin
            unique case (glq_pkg::cfg_idx_t'(cfg_addr))
                glq_pkg::CFG_ATLAS_WIDTH:  aw_reg       <= cfg_data[glq_pkg::ATLAS_W-1:0];
                glq_pkg::CFG_ATLAS_HEIGHT: ah_reg       <= cfg_data[glq_pkg::ATLAS_W-1:0];
                glq_pkg::CFG_GLYPH_SCALE:  scale_reg    <= cfg_data[glq_pkg::SCALE_W-1:0];
                glq_pkg::CFG_MAX_LINE:     line_max_reg <= cfg_data[POS_W-1:0];
                default:                   aw_reg       <= aw_reg;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ===== rtl/glq_checker.sv =====
// glq_checker: port-level checks for glyph_quad_layout, attached by bind
// depends on glq_pkg and the top level's port names
module glq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input glq_pkg::req_t req_data,
    input logic          res_valid,
    input logic          res_stall,
    input glq_pkg::res_t res_data
);

    // held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // a placement keeps the block busy
    a_place_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.mode == glq_pkg::MODE_PLACE |=> req_stall)
        else $error("request taken during a placement");

    // a table write does not stall the request channel
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.mode == glq_pkg::MODE_WRITE |=> !req_stall)
        else $error("table write held the request channel");

    // pen only moves forward and uv stays within one
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.x_right >= res_data.x_left
                   && res_data.u_left <= glq_pkg::UV_ONE
                   && res_data.u_right <= glq_pkg::UV_ONE
                   && res_data.v_bottom <= glq_pkg::UV_ONE
                   && res_data.v_top <= glq_pkg::UV_ONE)
        else $error("result out of range");

endmodule

bind glyph_quad_layout glq_checker u_glq_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for glyph_quad_layout, queue-fed driver and checking monitor
// depends on glq_pkg and the glyph_quad_layout rtl only
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 150;
    localparam int LONG_HOLD   = 400;

    localparam int CODE_W     = glq_pkg::CODE_W;
    localparam int FIELD_W    = glq_pkg::FIELD_W;
    localparam int ATLAS_W    = glq_pkg::ATLAS_W;
    localparam int SCALE_W    = glq_pkg::SCALE_W;
    localparam int POS_W      = glq_pkg::POS_W;
    localparam int UV_W       = glq_pkg::UV_W;
    localparam int UV_FRAC    = glq_pkg::UV_FRAC;
    localparam int QUAD_W     = glq_pkg::QUAD_W;
    localparam int CFG_IDX_W  = glq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = glq_pkg::CFG_DATA_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    glq_pkg::req_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    glq_pkg::res_t res_data;
    logic cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    glyph_quad_layout i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // layout state mirrored by the bench
    logic [FIELD_W-1:0] tab_w [256];
    logic [FIELD_W-1:0] tab_h [256];
    logic [FIELD_W-1:0] tab_x [256];
    logic [FIELD_W-1:0] tab_y [256];
    logic [POS_W-1:0]   pen_pos = '0;
    logic [QUAD_W-1:0]  quad_cnt = '0;
    logic               split_done = 1'b0;
    logic [ATLAS_W-1:0] atlas_w_cfg = glq_pkg::ATLAS_RESET;
    logic [ATLAS_W-1:0] atlas_h_cfg = glq_pkg::ATLAS_RESET;
    logic [SCALE_W-1:0] scale_cfg = glq_pkg::SCALE_RESET;
    logic [POS_W-1:0]   line_max_cfg = glq_pkg::LINE_MAX_RESET;

    glq_pkg::req_t pend_q [$];
    glq_pkg::res_t quad_q [$];
    bit   known [256];
    bit   quiet = 1'b0;
    int   mismatches = 0;
    int   quads_seen = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;

    function automatic logic [UV_W-1:0] uv_frac(input longint num, input longint den);
        longint q;
        if (num <= 0)
            return '0;
        if (den == 0)
            return glq_pkg::UV_ONE;
        q = (num << UV_FRAC) / den;
        return (q > longint'(glq_pkg::UV_ONE)) ? glq_pkg::UV_ONE : q[UV_W-1:0];
    endfunction

    // apply one accepted request to the mirrored state, queue the quad it yields
    task automatic layout_glyph(input glq_pkg::req_t r);
        glq_pkg::res_t q;
        longint prod;
        longint top;
        logic [POS_W:0]   sum;
        logic [POS_W-1:0] wid;
        logic [POS_W-1:0] right;
        logic [CODE_W-1:0] c;
        c = r.char_code;
        if (r.mode == glq_pkg::MODE_WRITE)
        begin
            tab_w[c] = r.glyph_w;
            tab_h[c] = r.glyph_h;
            tab_x[c] = r.glyph_x;
            tab_y[c] = r.glyph_y;
            return;
        end
        if (r.first_of_string)
        begin
            pen_pos = '0;
            quad_cnt = '0;
            split_done = 1'b0;
        end
        if (tab_h[c] == 0)
            wid = '0;
        else
        begin
            prod = longint'(scale_cfg) * longint'(tab_w[c]) / longint'(tab_h[c]);
            wid = (prod > longint'(glq_pkg::POS_MAX)) ? glq_pkg::POS_MAX : prod[POS_W-1:0];
        end
        sum = {1'b0, pen_pos} + {1'b0, wid};
        right = sum[POS_W] ? glq_pkg::POS_MAX : sum[POS_W-1:0];
        top = longint'(atlas_h_cfg) - longint'(tab_y[c]);
        q.x_left = pen_pos;
        q.x_right = right;
        q.u_left = uv_frac(longint'(tab_x[c]), longint'(atlas_w_cfg));
        q.u_right = uv_frac(longint'(tab_x[c]) + longint'(tab_w[c]), longint'(atlas_w_cfg));
        q.v_bottom = uv_frac(top - longint'(tab_h[c]), longint'(atlas_h_cfg));
        q.v_top = uv_frac(top, longint'(atlas_h_cfg));
        q.first_vertex = {quad_cnt, 2'b00};
        q.split_here = !split_done && line_max_cfg != 0 && right >= line_max_cfg;
        q.end_of_string = r.last_of_string;
        if (q.split_here)
            split_done = 1'b1;
        quad_q = {quad_q, q};
        pen_pos = right;
        quad_cnt = quad_cnt + QUAD_W'(1);
    endtask

    task automatic cmp_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_quad(input glq_pkg::res_t got);
        glq_pkg::res_t want;
        if (quad_q.size() == 0)
        begin
            $display("%0t ns: quad with none expected, got %h", $time, got);
            mismatches++;
            return;
        end
        want = quad_q.pop_front();
        cmp_field("x_left", want.x_left, got.x_left);
        cmp_field("x_right", want.x_right, got.x_right);
        cmp_field("u_left", POS_W'(want.u_left), POS_W'(got.u_left));
        cmp_field("u_right", POS_W'(want.u_right), POS_W'(got.u_right));
        cmp_field("v_bottom", POS_W'(want.v_bottom), POS_W'(got.v_bottom));
        cmp_field("v_top", POS_W'(want.v_top), POS_W'(got.v_top));
        cmp_field("first_vertex", POS_W'(want.first_vertex), POS_W'(got.first_vertex));
        cmp_field("split_here", POS_W'(want.split_here), POS_W'(got.split_here));
        cmp_field("end_of_string", POS_W'(want.end_of_string), POS_W'(got.end_of_string));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                layout_glyph(req_data);
            if (!(req_valid && req_stall))
            begin
                if (send_gap != 0)
                begin
                    req_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pend_q.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data <= pend_q.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 10);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            quads_seen <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                check_quad(res_data);
                quads_seen <= quads_seen + 1;
            end
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (res_valid && !res_stall && (quads_seen == 40 || quads_seen == 500))
            begin
                res_stall <= 1'b1;
                hold_left <= LONG_HOLD;
            end
            else if (stall_left != 0)
            begin
                res_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                res_stall <= 1'b1;
                stall_left <= $urandom_range(0, 9);
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return FIELD_W'($urandom);
            default: return FIELD_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] c;
        do
            c = CODE_W'($urandom_range(0, 255));
        while (!known[c]);
        return c;
    endfunction

    task automatic put_write(input logic [CODE_W-1:0] c, input logic [FIELD_W-1:0] w,
                             input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] x,
                             input logic [FIELD_W-1:0] y);
        glq_pkg::req_t r;
        r.mode = glq_pkg::MODE_WRITE;
        r.char_code = c;
        r.glyph_w = w;
        r.glyph_h = h;
        r.glyph_x = x;
        r.glyph_y = y;
        r.first_of_string = 1'($urandom);
        r.last_of_string = 1'($urandom);
        known[c] = 1'b1;
        pend_q = {pend_q, r};
    endtask

    task automatic put_place(input logic [CODE_W-1:0] c, input logic first, input logic last);
        glq_pkg::req_t r;
        r.mode = glq_pkg::MODE_PLACE;
        r.char_code = c;
        r.glyph_w = FIELD_W'($urandom);
        r.glyph_h = FIELD_W'($urandom);
        r.glyph_x = FIELD_W'($urandom);
        r.glyph_y = FIELD_W'($urandom);
        r.first_of_string = first;
        r.last_of_string = last;
        pend_q = {pend_q, r};
    endtask

    task automatic write_reg(input glq_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            glq_pkg::CFG_ATLAS_WIDTH:  atlas_w_cfg = val[ATLAS_W-1:0];
            glq_pkg::CFG_ATLAS_HEIGHT: atlas_h_cfg = val[ATLAS_W-1:0];
            glq_pkg::CFG_GLYPH_SCALE:  scale_cfg = val[SCALE_W-1:0];
            glq_pkg::CFG_MAX_LINE:     line_max_cfg = val[POS_W-1:0];
        endcase
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic set_layout(input int aw, input int ah, input int scale, input int line_max);
        write_reg(glq_pkg::CFG_ATLAS_WIDTH, CFG_DATA_W'(aw));
        write_reg(glq_pkg::CFG_ATLAS_HEIGHT, CFG_DATA_W'(ah));
        write_reg(glq_pkg::CFG_GLYPH_SCALE, CFG_DATA_W'(scale));
        write_reg(glq_pkg::CFG_MAX_LINE, CFG_DATA_W'(line_max));
        @(negedge clk);
    endtask

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic wait_idle();
        while (pend_q.size() != 0 || req_valid || quad_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed strings, some table writes, some stray and broken requests
    task automatic random_phase(input int n);
        int count;
        int kind;
        int len;
        bit drop_last;
        count = 0;
        while (count < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
            begin
                put_write(CODE_W'($urandom), rand_dim(), rand_dim(), rand_dim(), rand_dim());
                count++;
            end
            else if (kind < 20)
            begin
                put_place(pick_code(), 1'($urandom), 1'($urandom));
                count++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
                drop_last = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++)
                    put_place(pick_code(), i == 0, (i == len - 1) && !drop_last);
                count += len;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero height, far atlas corner, ignored string flags on writes
        put_write(8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
        put_write(8'hFF, 12'hFFF, 12'd1, 12'hFFF, 12'hFFF);
        put_write(8'h41, 12'd10, 12'd16, 12'd100, 12'd50);
        put_place(8'h00, 1'b1, 1'b0);
        put_place(8'h41, 1'b0, 1'b0);
        put_place(8'hFF, 1'b0, 1'b0);
        put_place(8'h41, 1'b0, 1'b1);
        put_write(8'h20, 12'd40, 12'd40, 12'd0, 12'd0);
        put_place(8'h20, 1'b1, 1'b1);
        wait_idle();

        // saturating width and pen, split then no second split, entry overwrite
        set_layout(4095, 4095, 65535, 24'h000800);
        put_place(8'hFF, 1'b1, 1'b0);
        put_place(8'h41, 1'b0, 1'b0);
        put_write(8'h41, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0);
        put_place(8'h41, 1'b0, 1'b1);
        wait_idle();

        // zero atlas size, zero scale, zero line limit
        set_layout(0, 0, 0, 0);
        put_place(8'h41, 1'b1, 1'b0);
        put_place(8'hFF, 1'b0, 1'b0);
        put_place(8'h00, 1'b0, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_layout(256, 256, 256, 24'h004000);
                1: set_layout(1, 1, 1, 1);
                2: set_layout(4095, 4095, 65535, 24'hFFFFFF);
                3: set_layout(512, 1024, 128, 0);
                default: set_layout($urandom_range(1, 4095), $urandom_range(1, 4095),
                                    $urandom_range(0, 65535), $urandom_range(1, 24'h8000));
            endcase
            if (ph == 7)
                quiet = 1'b1;
            random_phase(210);
            wait_idle();
        end

        if (mismatches == 0 && quad_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/glq_pkg.sv
rtl/glq_ram.sv
rtl/glq_div.sv
rtl/glyph_quad_layout.sv
rtl/glq_checker.sv
test/tb_top.sv
